>>> src/sc2a_pkg.sv
package sc2a_pkg;

  // Default ring size; the ring keeps one entry free to tell full from empty.
  localparam int unsigned FIFO_DEPTH = 64;

  // Keymap: two planes of 128 make codes, one byte each.
  localparam int unsigned KEYMAP_DEPTH = 256;
  localparam int unsigned KEYMAP_AW    = 8;
  localparam int unsigned CHAR_W       = 8;

  // Scancode set 1 values of interest.
  localparam logic [7:0] REL_BIT   = 8'h80;
  localparam logic [7:0] SC_LSHIFT = 8'h2A;
  localparam logic [7:0] SC_RSHIFT = 8'h36;
  localparam logic [7:0] SC_CAPS   = 8'h3A;
  localparam logic [7:0] NO_CHAR   = 8'h00;

  // Item commands.
  typedef enum logic [1:0] {
    CMD_SCAN = 2'd0,
    CMD_POP  = 2'd1,
    CMD_LOAD = 2'd2
  } cmd_e;

endpackage

>>> src/sc2a_ram.sv
module sc2a_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port; a read holds its data until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/scancode_to_ascii_fifo.sv
// Set-1 keyboard scancode decoder with a character ring.
//
// Input channel (in_valid_i / in_ready_o) carries one command per item: a
// scancode, a pop of the oldest character, or a keymap load. Output channel
// (out_valid_o / out_ready_i) returns exactly one result item per input item,
// in order: the popped character, the drop flag and the shift and caps flags.
//
// An item accepted at the input passes the stage 1 register and then the
// output register. One item per cycle is sustained while results are taken:
// the keymap RAM and the ring RAM are each read once at acceptance and the
// ring is written at most once in the second stage, where the pointers move.
//
// Reset clears the shift and caps flags, the ring pointers and the per-entry
// keymap valid bits, so every keymap entry reads as zero until it is loaded. There is no
// clearing pass; items are taken from the first cycle after reset.
//
// When the receiver stalls, the result waits in the output register and the
// second stage holds one more item; the input side then deasserts ready
// until the output register drains.
module scancode_to_ascii_fifo
  import sc2a_pkg::*;
#(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] scancode_i,
  input  logic       map_plane_i,
  input  logic [6:0] map_index_i,
  input  logic [7:0] map_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       char_valid_o,
  output logic [7:0] char_value_o,
  output logic       key_dropped_o,
  output logic       shift_active_o,
  output logic       caps_active_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);

  typedef struct packed {
    cmd_e              cmd;
    logic              lookup;
    logic              kvalid;
    logic              fwd;
    logic [CHAR_W-1:0] fwd_char;
    logic              shift;
    logic              caps;
  } s1_t;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(FifoDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  logic                in_fire, s1_fire;
  logic                s1_v_q;
  s1_t                 s1_q, s1_d;
  logic                out_v_q;
  logic                shift_q, shift_d, caps_q, caps_d;
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_nxt;
  logic [KEYMAP_DEPTH-1:0] kvld_q;
  cmd_e                cmd;
  logic                press, is_shift, is_caps;
  logic [KEYMAP_AW-1:0] km_raddr, km_waddr;
  logic                km_we;
  logic [CHAR_W-1:0]   km_rdata, ring_rdata, ch;
  logic                full, empty, has_char, push, drop, pop_ok;
  logic [CHAR_W-1:0]   pop_char;
  logic                res_valid, res_drop;
  logic [CHAR_W-1:0]   res_char;

  // Handshakes: stage 1 moves on when the output register is free or being taken.
  assign s1_fire    = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // Stage 0 decode of the arriving item.
  assign cmd      = cmd_e'(cmd_i);
  assign press    = (scancode_i & REL_BIT) == 8'h00;
  assign is_shift = (scancode_i[6:0] == SC_LSHIFT[6:0]) || (scancode_i[6:0] == SC_RSHIFT[6:0]);
  assign is_caps  = scancode_i == SC_CAPS;

  // Shift and caps flags change at acceptance, so the next item sees them at once.
  always_comb begin
    shift_d = shift_q;
    caps_d  = caps_q;
    if (in_fire && cmd == CMD_SCAN) begin
      if (press) begin
        if (is_shift) begin
          shift_d = 1'b1;
        end else if (is_caps) begin
          caps_d = ~caps_q;
        end
      end else if (is_shift) begin
        shift_d = 1'b0;
      end
    end
  end

  // Keymap access: loads write at acceptance, presses read the active plane.
  assign km_raddr = {shift_q ^ caps_q, scancode_i[6:0]};
  assign km_waddr = {map_plane_i, map_index_i};
  assign km_we    = in_fire && cmd == CMD_LOAD;

  sc2a_ram #(
    .Width (CHAR_W),
    .Depth (KEYMAP_DEPTH)
  ) u_keymap (
    .clk_i   (clk_i),
    .we_i    (km_we),
    .waddr_i (km_waddr),
    .wdata_i (map_char_i),
    .re_i    (in_fire),
    .raddr_i (km_raddr),
    .rdata_o (km_rdata)
  );

  // Stage 1: ring occupancy and the push or pop of the item held there.
  assign wr_nxt   = ptr_inc(wr_ptr_q);
  assign full     = wr_nxt == rd_ptr_q;
  assign empty    = wr_ptr_q == rd_ptr_q;
  assign ch       = s1_q.kvalid ? km_rdata : NO_CHAR;
  assign has_char = s1_v_q && s1_q.lookup && (ch != NO_CHAR);
  assign push     = has_char && !full;
  assign drop     = has_char && full;
  assign pop_ok   = s1_v_q && s1_q.cmd == CMD_POP && !empty;
  assign pop_char = s1_q.fwd ? s1_q.fwd_char : ring_rdata;

  assign wr_ptr_d = (s1_fire && push) ? wr_nxt : wr_ptr_q;
  assign rd_ptr_d = (s1_fire && pop_ok) ? ptr_inc(rd_ptr_q) : rd_ptr_q;

  // The ring is read at the pointer as it stands after stage 1; a write to
  // that same entry in this cycle is forwarded around the RAM.
  sc2a_ram #(
    .Width (CHAR_W),
    .Depth (FifoDepth)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (s1_fire && push),
    .waddr_i (wr_ptr_q),
    .wdata_i (ch),
    .re_i    (in_fire),
    .raddr_i (rd_ptr_d),
    .rdata_o (ring_rdata)
  );

  // Stage 1 payload captured at acceptance.
  always_comb begin
    s1_d.cmd      = cmd;
    s1_d.lookup   = cmd == CMD_SCAN && press && !is_shift && !is_caps;
    s1_d.kvalid   = kvld_q[km_raddr];
    s1_d.fwd      = s1_fire && push && (wr_ptr_q == rd_ptr_d);
    s1_d.fwd_char = ch;
    s1_d.shift    = shift_d;
    s1_d.caps     = caps_d;
  end

  // Result of the item leaving stage 1.
  assign res_valid = pop_ok;
  assign res_char  = pop_ok ? pop_char : NO_CHAR;
  assign res_drop  = drop;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
      shift_q  <= 1'b0;
      caps_q   <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      kvld_q   <= '0;
    end else begin
      if (in_fire) begin
        s1_v_q <= 1'b1;
      end else if (s1_fire) begin
        s1_v_q <= 1'b0;
      end
      if (s1_fire) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      shift_q  <= shift_d;
      caps_q   <= caps_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      if (km_we) begin
        kvld_q[km_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers of stage 1 and of the output.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    if (s1_fire) begin
      char_valid_o   <= res_valid;
      char_value_o   <= res_char;
      key_dropped_o  <= res_drop;
      shift_active_o <= s1_q.shift;
      caps_active_o  <= s1_q.caps;
    end
  end

  assign out_valid_o = out_v_q;

endmodule
